// ===== design/price_time_order_book_defines.svh =====
// assertion macros used by the order book datapath
`ifndef PRICE_TIME_ORDER_BOOK_DEFINES_SVH
`define PRICE_TIME_ORDER_BOOK_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTOB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("property failed");
`define PTOB_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden condition");
`else
`define PTOB_ASSERT(label, clk, rst_n, prop)
`define PTOB_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/ptob_pkg.sv =====
`default_nettype none
package ptob_pkg;

	localparam int MAX_ORDERS = 1024;
	localparam int ORD_AW     = $clog2(MAX_ORDERS);
	localparam int LINK_W     = ORD_AW + 1;
	localparam int MAX_LEVELS = 64;
	localparam int LVL_AW     = $clog2(MAX_LEVELS);
	localparam int CNT_W      = LVL_AW + 1;
	localparam int PRICE_W    = 16;
	localparam int MAX_SNAP   = 8;
	localparam int GOT_W      = $clog2(MAX_SNAP + 1);
	localparam int DEPTH_W    = 4;
	localparam int DEPTH_RST  = 8;

	localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_ORDERS);

	typedef enum logic [1:0] {
		FN_INSERT   = 2'd0,
		FN_REMOVE   = 2'd1,
		FN_SNAPSHOT = 2'd2,
		FN_SPARE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNKNOWN  = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_RD_ORD, OP_CAP_LINKS, OP_RD_LVL, OP_LV_INC,
		OP_TAKE_LVL, OP_SH_INIT, OP_SHU_RD, OP_SHU_WR, OP_NEWLVL, OP_INS_ORD,
		OP_RD_PTR, OP_WR_PTR_NEXT, OP_WR_LVL, OP_SET_HEAD, OP_RD_NXT,
		OP_WR_NXT_PREV, OP_SET_TAIL, OP_FREE, OP_SD_INIT, OP_SHD_RD, OP_SHD_WR,
		OP_CNT_DEC, OP_BEST_INIT, OP_EMIT_BEST, OP_SNAP_INIT, OP_SNAP_SIDE1,
		OP_SN_HEAD, OP_SN_EMIT, OP_SN_NEXT, OP_SN_PAD
	} op_t;

	typedef struct packed {
		logic                used;
		logic                side;
		logic [PRICE_W-1:0]  price;
		logic [LINK_W-1:0]   prv;
		logic [LINK_W-1:0]   nxt;
	} ord_rec_t;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [LINK_W-1:0]   head;
		logic [LINK_W-1:0]   tail;
	} lvl_rec_t;

	typedef struct packed {
		op_t     op;
		status_t st;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  clr_last;
		logic  ord_used;
		logic  ord_match;
		logic  lv_end;
		logic  lvl_eq;
		logic  lvl_better;
		logic  cnt_full;
		logic  i_at_lv;
		logic  i_last;
		logic  ptr_null;
		logic  nxt_null;
		logic  lvl_empty;
		logic  got_full;
		logic  sd;
		logic  out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/price_time_order_book.sv =====
// limit order book with price-time priority: up to 1024 resting orders (ids 0..1023) and
// up to 64 price levels per side, each level a fifo of orders. after reset the block sweeps
// the order table with req_stall high before it takes the first request. one request is
// worked at a time. insert and remove scan the price levels to find the order's level and
// shift the levels behind it when a level is opened or closed (the level table has one read
// and one write port, so every move is a read then a write); each answers with a best bid
// beat then a best ask beat. a snapshot walks the levels and their orders in book order,
// pads empty slots, clamps the depth to 1..8 and sends 2*depth
// beats, bids first. result beats are held in an output register, so a stalled consumer
// only holds the sequencer when it wants to send the next beat. the snapshot depth register
// is written through the cfg channel, which is always ready, and must be written only while
// the book is idle.
`default_nettype none
module price_time_order_book import ptob_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	// request channel
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire  [1:0]          func,
	input  wire  [ORD_AW-1:0]   oid,
	input  wire                 side,
	input  wire  [PRICE_W-1:0]  price,
	// result channel
	output logic                res_valid,
	input  wire                 res_stall,
	output logic [2:0]          status,
	output logic                side_res,
	output logic                valid_res,
	output logic [ORD_AW-1:0]   oid_res,
	output logic [PRICE_W-1:0]  price_res,
	output logic                last,
	// snapshot depth register
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [DEPTH_W-1:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// the register write never waits
	assign cfg_ready = 1'b1;

	// sequencer: walks the request through scan, shift, link and report steps
	ptob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// order table, level table, counts, working registers and result beat register
	ptob_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.oid          (oid),
		.side         (side),
		.price        (price),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.side_res     (side_res),
		.valid_res    (valid_res),
		.oid_res      (oid_res),
		.price_res    (price_res),
		.last         (last)
	);

endmodule
`default_nettype wire

// ===== design/ptob_ctrl.sv =====
`default_nettype none
module ptob_ctrl import ptob_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   req_valid,
	output logic  req_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_ORD_CHK, S_FIND_RD, S_FIND_CHK, S_NEW_LVL,
		S_SHU_CHK, S_SHU_WR, S_INS_ORD, S_INS_LINK, S_PTR_WR, S_WR_LVL, S_RM_PREV,
		S_RM_NEXT, S_NXT_WR, S_RM_FREE, S_RM_LVL, S_SHD_CHK, S_SHD_WR, S_FIN,
		S_BEST_RD, S_BEST_EM, S_SN_LV, S_SN_HEAD, S_SN_ORD, S_SN_NEXT, S_SN_PAD
	} state_t;

	state_t state_q, state_nx;
	logic   is_ins;

	assign is_ins    = (stat.func == FN_INSERT);
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		cmd.st   = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.func)
					FN_INSERT, FN_REMOVE: begin
						cmd.op   = OP_RD_ORD;
						state_nx = S_ORD_CHK;
					end
					FN_SNAPSHOT: begin
						cmd.op   = OP_SNAP_INIT;
						state_nx = S_SN_LV;
					end
					default: begin
						cmd.op   = OP_BEST_INIT;
						state_nx = S_BEST_RD;
					end
				endcase
			end
			S_ORD_CHK: begin
				if (is_ins) begin
					if (stat.ord_used) begin
						cmd.op   = OP_BEST_INIT;
						cmd.st   = ST_DUP;
						state_nx = S_BEST_RD;
					end else begin
						state_nx = S_FIND_RD;
					end
				end else if (!stat.ord_used) begin
					cmd.op   = OP_BEST_INIT;
					cmd.st   = ST_UNKNOWN;
					state_nx = S_BEST_RD;
				end else if (!stat.ord_match) begin
					cmd.op   = OP_BEST_INIT;
					cmd.st   = ST_MISMATCH;
					state_nx = S_BEST_RD;
				end else begin
					cmd.op   = OP_CAP_LINKS;
					state_nx = S_FIND_RD;
				end
			end
			S_FIND_RD: begin
				if (stat.lv_end) begin
					if (is_ins) begin
						state_nx = S_NEW_LVL;
					end else begin
						cmd.op   = OP_BEST_INIT;
						cmd.st   = ST_MISMATCH;
						state_nx = S_BEST_RD;
					end
				end else begin
					cmd.op   = OP_RD_LVL;
					state_nx = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if (stat.lvl_eq) begin
					cmd.op   = OP_TAKE_LVL;
					state_nx = is_ins ? S_INS_ORD : S_RM_PREV;
				end else if (stat.lvl_better) begin
					if (is_ins) begin
						state_nx = S_NEW_LVL;
					end else begin
						cmd.op   = OP_BEST_INIT;
						cmd.st   = ST_MISMATCH;
						state_nx = S_BEST_RD;
					end
				end else begin
					cmd.op   = OP_LV_INC;
					state_nx = S_FIND_RD;
				end
			end
			S_NEW_LVL: begin
				if (stat.cnt_full) begin
					cmd.op   = OP_BEST_INIT;
					cmd.st   = ST_FULL;
					state_nx = S_BEST_RD;
				end else begin
					cmd.op   = OP_SH_INIT;
					state_nx = S_SHU_CHK;
				end
			end
			S_SHU_CHK: begin
				if (stat.i_at_lv) begin
					cmd.op   = OP_NEWLVL;
					state_nx = S_INS_ORD;
				end else begin
					cmd.op   = OP_SHU_RD;
					state_nx = S_SHU_WR;
				end
			end
			S_SHU_WR: begin
				cmd.op   = OP_SHU_WR;
				state_nx = S_SHU_CHK;
			end
			S_INS_ORD: begin
				cmd.op   = OP_INS_ORD;
				state_nx = S_INS_LINK;
			end
			S_INS_LINK: begin
				if (stat.ptr_null) begin
					cmd.op   = OP_WR_LVL;
					state_nx = S_FIN;
				end else begin
					cmd.op   = OP_RD_PTR;
					state_nx = S_PTR_WR;
				end
			end
			S_PTR_WR: begin
				cmd.op   = OP_WR_PTR_NEXT;
				state_nx = is_ins ? S_WR_LVL : S_RM_NEXT;
			end
			S_WR_LVL: begin
				cmd.op   = OP_WR_LVL;
				state_nx = S_FIN;
			end
			S_RM_PREV: begin
				if (stat.ptr_null) begin
					cmd.op   = OP_SET_HEAD;
					state_nx = S_RM_NEXT;
				end else begin
					cmd.op   = OP_RD_PTR;
					state_nx = S_PTR_WR;
				end
			end
			S_RM_NEXT: begin
				if (stat.nxt_null) begin
					cmd.op   = OP_SET_TAIL;
					state_nx = S_RM_FREE;
				end else begin
					cmd.op   = OP_RD_NXT;
					state_nx = S_NXT_WR;
				end
			end
			S_NXT_WR: begin
				cmd.op   = OP_WR_NXT_PREV;
				state_nx = S_RM_FREE;
			end
			S_RM_FREE: begin
				cmd.op   = OP_FREE;
				state_nx = S_RM_LVL;
			end
			S_RM_LVL: begin
				if (stat.lvl_empty) begin
					cmd.op   = OP_SD_INIT;
					state_nx = S_SHD_CHK;
				end else begin
					cmd.op   = OP_WR_LVL;
					state_nx = S_FIN;
				end
			end
			S_SHD_CHK: begin
				if (stat.i_last) begin
					cmd.op   = OP_CNT_DEC;
					state_nx = S_FIN;
				end else begin
					cmd.op   = OP_SHD_RD;
					state_nx = S_SHD_WR;
				end
			end
			S_SHD_WR: begin
				cmd.op   = OP_SHD_WR;
				state_nx = S_SHD_CHK;
			end
			S_FIN: begin
				cmd.op   = OP_BEST_INIT;
				state_nx = S_BEST_RD;
			end
			S_BEST_RD: begin
				cmd.op   = OP_RD_LVL;
				state_nx = S_BEST_EM;
			end
			S_BEST_EM: begin
				if (stat.out_free) begin
					cmd.op   = OP_EMIT_BEST;
					state_nx = stat.sd ? S_IDLE : S_BEST_RD;
				end
			end
			S_SN_LV: begin
				if (stat.got_full || stat.lv_end) begin
					state_nx = S_SN_PAD;
				end else begin
					cmd.op   = OP_RD_LVL;
					state_nx = S_SN_HEAD;
				end
			end
			S_SN_HEAD: begin
				cmd.op   = OP_SN_HEAD;
				state_nx = S_SN_ORD;
			end
			S_SN_ORD: begin
				if (stat.ptr_null || stat.got_full) begin
					cmd.op   = OP_LV_INC;
					state_nx = S_SN_LV;
				end else if (stat.out_free) begin
					cmd.op   = OP_SN_EMIT;
					state_nx = S_SN_NEXT;
				end
			end
			S_SN_NEXT: begin
				cmd.op   = OP_SN_NEXT;
				state_nx = S_SN_ORD;
			end
			S_SN_PAD: begin
				if (stat.got_full) begin
					if (stat.sd) begin
						state_nx = S_IDLE;
					end else begin
						cmd.op   = OP_SNAP_SIDE1;
						state_nx = S_SN_LV;
					end
				end else if (stat.out_free) begin
					cmd.op = OP_SN_PAD;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule
`default_nettype wire

// ===== design/ptob_dpath.sv =====
`default_nettype none
`include "price_time_order_book_defines.svh"
module ptob_dpath import ptob_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  wire  [1:0]          func,
	input  wire  [ORD_AW-1:0]   oid,
	input  wire                 side,
	input  wire  [PRICE_W-1:0]  price,
	input  wire                 cfg_we,
	input  wire  [DEPTH_W-1:0]  cfg_data,
	output logic                res_valid,
	input  wire                 res_stall,
	output logic [2:0]          status,
	output logic                side_res,
	output logic                valid_res,
	output logic [ORD_AW-1:0]   oid_res,
	output logic [PRICE_W-1:0]  price_res,
	output logic                last
);

	ord_rec_t ord_mem [MAX_ORDERS];
	lvl_rec_t lvl_mem [2*MAX_LEVELS];

	func_t              func_q;
	logic [ORD_AW-1:0]  id_q;
	logic [PRICE_W-1:0] price_q;
	logic               sd_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [CNT_W-1:0]   cnt_q [2];
	status_t            status_q;
	logic [CNT_W-1:0]   lv_q;
	logic [CNT_W-1:0]   i_q;
	lvl_rec_t           lvl_q;
	lvl_rec_t           lvlr_q;
	ord_rec_t           ordr_q;
	logic [LINK_W-1:0]  ptr_q;
	logic [LINK_W-1:0]  nxt_q;
	logic [GOT_W-1:0]   got_q;
	logic [ORD_AW-1:0]  clr_q;
	logic               res_valid_q;

	logic [CNT_W-1:0]   cnt_cur;
	logic [GOT_W-1:0]   eff_depth;
	logic [CNT_W-1:0]   i_dn;
	logic [CNT_W-1:0]   i_up;
	logic               out_free;
	logic               emit;
	logic [2:0]         e_status;
	logic               e_valid;
	logic [ORD_AW-1:0]  e_id;
	logic [PRICE_W-1:0] e_price;
	logic               e_last;

	logic               ord_we, ord_re;
	logic [ORD_AW-1:0]  ord_waddr, ord_raddr;
	ord_rec_t           ord_wdata;
	logic               lvl_we, lvl_re;
	logic [LVL_AW:0]    lvl_waddr, lvl_raddr;
	lvl_rec_t           lvl_wdata;

	assign cnt_cur  = cnt_q[sd_q];
	assign i_dn     = i_q - CNT_W'(1);
	assign i_up     = i_q + CNT_W'(1);
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		if (depth_q == '0) begin
			eff_depth = GOT_W'(1);
		end else if (depth_q > DEPTH_W'(MAX_SNAP)) begin
			eff_depth = GOT_W'(MAX_SNAP);
		end else begin
			eff_depth = GOT_W'(depth_q);
		end
	end

	always_comb begin
		stat.func       = func_q;
		stat.clr_last   = (clr_q == '1);
		stat.ord_used   = ordr_q.used;
		stat.ord_match  = (ordr_q.side == sd_q) && (ordr_q.price == price_q);
		stat.lv_end     = (lv_q >= cnt_cur);
		stat.lvl_eq     = (lvlr_q.price == price_q);
		stat.lvl_better = sd_q ? (price_q < lvlr_q.price) : (price_q > lvlr_q.price);
		stat.cnt_full   = (cnt_cur == CNT_W'(MAX_LEVELS));
		stat.i_at_lv    = (i_q == lv_q);
		stat.i_last     = ({1'b0, i_q} + (CNT_W+1)'(1)) >= {1'b0, cnt_cur};
		stat.ptr_null   = ptr_q[LINK_W-1];
		stat.nxt_null   = nxt_q[LINK_W-1];
		stat.lvl_empty  = lvl_q.head[LINK_W-1];
		stat.got_full   = (got_q == eff_depth);
		stat.sd         = sd_q;
		stat.out_free   = out_free;
	end

	// memory port steering
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = id_q;
		ord_wdata = ordr_q;
		ord_re    = 1'b0;
		ord_raddr = id_q;
		lvl_we    = 1'b0;
		lvl_waddr = {sd_q, i_q[LVL_AW-1:0]};
		lvl_wdata = lvlr_q;
		lvl_re    = 1'b0;
		lvl_raddr = {sd_q, lv_q[LVL_AW-1:0]};
		case (cmd.op)
			OP_CLR: begin
				ord_we    = 1'b1;
				ord_waddr = clr_q;
				ord_wdata = '0;
			end
			OP_RD_ORD: ord_re = 1'b1;
			OP_RD_PTR, OP_SN_EMIT: begin
				ord_re    = 1'b1;
				ord_raddr = ptr_q[ORD_AW-1:0];
			end
			OP_RD_NXT: begin
				ord_re    = 1'b1;
				ord_raddr = nxt_q[ORD_AW-1:0];
			end
			OP_INS_ORD: begin
				ord_we    = 1'b1;
				ord_wdata = '{used: 1'b1, side: sd_q, price: price_q,
					prv: lvl_q.tail, nxt: NO_LINK};
			end
			OP_WR_PTR_NEXT: begin
				ord_we        = 1'b1;
				ord_waddr     = ptr_q[ORD_AW-1:0];
				ord_wdata.nxt = nxt_q;
			end
			OP_WR_NXT_PREV: begin
				ord_we        = 1'b1;
				ord_waddr     = nxt_q[ORD_AW-1:0];
				ord_wdata.prv = ptr_q;
			end
			OP_FREE: begin
				ord_we    = 1'b1;
				ord_wdata = '0;
			end
			OP_RD_LVL: lvl_re = 1'b1;
			OP_SHU_RD: begin
				lvl_re    = 1'b1;
				lvl_raddr = {sd_q, i_dn[LVL_AW-1:0]};
			end
			OP_SHD_RD: begin
				lvl_re    = 1'b1;
				lvl_raddr = {sd_q, i_up[LVL_AW-1:0]};
			end
			OP_SHU_WR, OP_SHD_WR: lvl_we = 1'b1;
			OP_WR_LVL: begin
				lvl_we    = 1'b1;
				lvl_waddr = {sd_q, lv_q[LVL_AW-1:0]};
				lvl_wdata = lvl_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
		if (ord_re) ordr_q <= ord_mem[ord_raddr];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
		if (lvl_re) lvlr_q <= lvl_mem[lvl_raddr];
	end

	// result beat contents
	always_comb begin
		emit     = 1'b0;
		e_status = status_q;
		e_valid  = 1'b0;
		e_id     = '0;
		e_price  = '0;
		e_last   = 1'b0;
		case (cmd.op)
			OP_EMIT_BEST: begin
				emit    = 1'b1;
				e_valid = (cnt_cur != '0);
				e_id    = e_valid ? lvlr_q.head[ORD_AW-1:0] : '0;
				e_price = e_valid ? lvlr_q.price : '0;
				e_last  = sd_q;
			end
			OP_SN_EMIT: begin
				emit     = 1'b1;
				e_status = ST_OK;
				e_valid  = 1'b1;
				e_id     = ptr_q[ORD_AW-1:0];
				e_price  = lvl_q.price;
				e_last   = sd_q && ((got_q + GOT_W'(1)) == eff_depth);
			end
			OP_SN_PAD: begin
				emit     = 1'b1;
				e_status = ST_OK;
				e_last   = sd_q && ((got_q + GOT_W'(1)) == eff_depth);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status       <= e_status;
			side_res     <= sd_q;
			valid_res    <= e_valid;
			oid_res      <= e_id;
			price_res    <= e_price;
			last         <= e_last;
		end
	end

	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			depth_q     <= DEPTH_W'(DEPTH_RST);
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			clr_q       <= '0;
			func_q      <= FN_INSERT;
			id_q        <= '0;
			price_q     <= '0;
			status_q    <= ST_OK;
			sd_q        <= 1'b0;
			lv_q        <= '0;
			i_q         <= '0;
			lvl_q       <= '0;
			got_q       <= '0;
			ptr_q       <= NO_LINK;
			nxt_q       <= NO_LINK;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) depth_q <= cfg_data;
			case (cmd.op)
				OP_CLR: clr_q <= clr_q + ORD_AW'(1);
				OP_LOAD: begin
					func_q   <= func_t'(func);
					id_q     <= oid;
					price_q  <= price;
					sd_q     <= side;
					lv_q     <= '0;
					status_q <= ST_OK;
				end
				OP_CAP_LINKS: begin
					ptr_q <= ordr_q.prv;
					nxt_q <= ordr_q.nxt;
				end
				OP_LV_INC: lv_q <= lv_q + CNT_W'(1);
				OP_TAKE_LVL: lvl_q <= lvlr_q;
				OP_SH_INIT: i_q <= cnt_cur;
				OP_SHU_WR: i_q <= i_dn;
				OP_SHD_WR: i_q <= i_up;
				OP_SD_INIT: i_q <= lv_q;
				OP_NEWLVL: begin
					cnt_q[sd_q] <= cnt_cur + CNT_W'(1);
					lvl_q       <= '{price: price_q, head: NO_LINK, tail: NO_LINK};
				end
				OP_CNT_DEC: cnt_q[sd_q] <= cnt_cur - CNT_W'(1);
				OP_INS_ORD: begin
					ptr_q <= lvl_q.tail;
					nxt_q <= {1'b0, id_q};
					if (lvl_q.tail[LINK_W-1]) lvl_q.head <= {1'b0, id_q};
					lvl_q.tail <= {1'b0, id_q};
				end
				OP_SET_HEAD: lvl_q.head <= nxt_q;
				OP_SET_TAIL: lvl_q.tail <= ptr_q;
				OP_BEST_INIT: begin
					status_q <= cmd.st;
					sd_q     <= 1'b0;
					lv_q     <= '0;
				end
				OP_EMIT_BEST: sd_q <= 1'b1;
				OP_SNAP_INIT: begin
					sd_q  <= 1'b0;
					lv_q  <= '0;
					got_q <= '0;
				end
				OP_SNAP_SIDE1: begin
					sd_q  <= 1'b1;
					lv_q  <= '0;
					got_q <= '0;
				end
				OP_SN_HEAD: begin
					lvl_q <= lvlr_q;
					ptr_q <= lvlr_q.head;
				end
				OP_SN_EMIT, OP_SN_PAD: got_q <= got_q + GOT_W'(1);
				OP_SN_NEXT: ptr_q <= ordr_q.nxt;
				default: begin
				end
			endcase
		end
	end

	`PTOB_NEVER(a_emit_over_held, clk, arst_n, res_valid_q && res_stall && emit)
	`PTOB_ASSERT(a_cnt0_range, clk, arst_n, cnt_q[0] <= CNT_W'(MAX_LEVELS))
	`PTOB_ASSERT(a_cnt1_range, clk, arst_n, cnt_q[1] <= CNT_W'(MAX_LEVELS))
	`PTOB_NEVER(a_snap_null_ptr, clk, arst_n, (cmd.op == OP_SN_EMIT) && ptr_q[LINK_W-1])
	`PTOB_ASSERT(a_shift_room, clk, arst_n, (cmd.op == OP_SH_INIT) |-> (cnt_cur < CNT_W'(MAX_LEVELS)))

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import ptob_pkg::*;

	// request beat as the driver sends it
	typedef struct packed {
		logic [1:0]         func;
		logic [ORD_AW-1:0]  oid;
		logic               side;
		logic [PRICE_W-1:0] price;
	} order_req_t;

	// one result beat of the book
	typedef struct packed {
		logic [2:0]         status;
		logic               side_res;
		logic               valid_res;
		logic [ORD_AW-1:0]  oid_res;
		logic [PRICE_W-1:0] price_res;
		logic               last;
	} book_beat_t;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int NIL = MAX_ORDERS;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [1:0] func;
	logic [ORD_AW-1:0] oid;
	logic side;
	logic [PRICE_W-1:0] price;
	logic res_valid;
	logic res_stall;
	logic [2:0] status;
	logic side_res;
	logic valid_res;
	logic [ORD_AW-1:0] oid_res;
	logic [PRICE_W-1:0] price_res;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [DEPTH_W-1:0] cfg_data;

	price_time_order_book i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .oid(oid), .side(side), .price(price),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .side_res(side_res), .valid_res(valid_res),
		.oid_res(oid_res), .price_res(price_res), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// shadow copy of the book
	bit                ord_used [MAX_ORDERS];
	bit                ord_side [MAX_ORDERS];
	logic [PRICE_W-1:0] ord_price [MAX_ORDERS];
	int                ord_prv [MAX_ORDERS];
	int                ord_nxt [MAX_ORDERS];
	logic [PRICE_W-1:0] lvl_price [2][MAX_LEVELS];
	int                lvl_head [2][MAX_LEVELS];
	int                lvl_tail [2][MAX_LEVELS];
	int                lvl_cnt [2];
	int                depth_reg;

	order_req_t pending_reqs[$];
	book_beat_t expected_beats[$];
	int  error_count;
	int  cycle_count;
	bit  req_taken;
	int  req_wait;
	int  res_wait;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic int find_lvl(input int s, input logic [PRICE_W-1:0] p);
		for (int i = 0; i < lvl_cnt[s]; i++)
			if (lvl_price[s][i] == p)
				return i;
		return lvl_cnt[s];
	endfunction

	function automatic status_t book_insert(input int id, input int s,
			input logic [PRICE_W-1:0] p);
		int lv;
		if (ord_used[id])
			return ST_DUP;
		lv = find_lvl(s, p);
		if (lv >= lvl_cnt[s]) begin
			if (lvl_cnt[s] >= MAX_LEVELS)
				return ST_FULL;
			lv = 0;
			// bids best at top (highest), asks lowest first
			while (lv < lvl_cnt[s] && !(s ? p < lvl_price[s][lv] : p > lvl_price[s][lv]))
				lv++;
			for (int i = lvl_cnt[s]; i > lv; i--) begin
				lvl_price[s][i] = lvl_price[s][i-1];
				lvl_head[s][i] = lvl_head[s][i-1];
				lvl_tail[s][i] = lvl_tail[s][i-1];
			end
			lvl_price[s][lv] = p;
			lvl_head[s][lv] = NIL;
			lvl_tail[s][lv] = NIL;
			lvl_cnt[s]++;
		end
		ord_used[id] = 1;
		ord_side[id] = s;
		ord_price[id] = p;
		ord_prv[id] = lvl_tail[s][lv];
		ord_nxt[id] = NIL;
		if (lvl_tail[s][lv] < NIL)
			ord_nxt[lvl_tail[s][lv]] = id;
		else
			lvl_head[s][lv] = id;
		lvl_tail[s][lv] = id;
		return ST_OK;
	endfunction

	function automatic status_t book_remove(input int id, input int s,
			input logic [PRICE_W-1:0] p);
		int lv;
		int pv;
		int nx;
		if (!ord_used[id])
			return ST_UNKNOWN;
		if (ord_side[id] != s || ord_price[id] != p)
			return ST_MISMATCH;
		lv = find_lvl(s, p);
		if (lv >= lvl_cnt[s])
			return ST_MISMATCH;
		pv = ord_prv[id];
		nx = ord_nxt[id];
		if (pv < NIL) ord_nxt[pv] = nx; else lvl_head[s][lv] = nx;
		if (nx < NIL) ord_prv[nx] = pv; else lvl_tail[s][lv] = pv;
		ord_used[id] = 0;
		if (lvl_head[s][lv] >= NIL) begin
			for (int i = lv; i + 1 < lvl_cnt[s]; i++) begin
				lvl_price[s][i] = lvl_price[s][i+1];
				lvl_head[s][i] = lvl_head[s][i+1];
				lvl_tail[s][i] = lvl_tail[s][i+1];
			end
			lvl_cnt[s]--;
		end
		return ST_OK;
	endfunction

	function automatic book_beat_t make_beat(input status_t st, input int s, input bit v,
			input int id, input logic [PRICE_W-1:0] p, input bit lst);
		book_beat_t b;
		b.status = st;
		b.side_res = s[0];
		b.valid_res = v;
		b.oid_res = v ? id[ORD_AW-1:0] : '0;
		b.price_res = v ? p : '0;
		b.last = lst;
		return b;
	endfunction

	// apply one request to the shadow book and queue the beats it produces
	task automatic predict_book(input order_req_t r);
		status_t st;
		int d;
		int got;
		int o;
		st = ST_OK;
		if (r.func == FN_SNAPSHOT) begin
			d = depth_reg < 1 ? 1 : (depth_reg > MAX_SNAP ? MAX_SNAP : depth_reg);
			for (int s = 0; s < 2; s++) begin
				got = 0;
				for (int lv = 0; lv < lvl_cnt[s] && got < d; lv++) begin
					o = lvl_head[s][lv];
					while (o < NIL && got < d) begin
						expected_beats = {expected_beats, make_beat(ST_OK, s, 1, o,
							lvl_price[s][lv], s == 1 && got == d - 1)};
						got++;
						o = ord_nxt[o];
					end
				end
				for (; got < d; got++)
					expected_beats = {expected_beats, make_beat(ST_OK, s, 0, 0, 0,
						s == 1 && got == d - 1)};
			end
			return;
		end
		if (r.func == FN_INSERT)
			st = book_insert(r.oid, r.side, r.price);
		else if (r.func == FN_REMOVE)
			st = book_remove(r.oid, r.side, r.price);
		for (int s = 0; s < 2; s++)
			if (lvl_cnt[s] > 0)
				expected_beats = {expected_beats, make_beat(st, s, 1, lvl_head[s][0],
					lvl_price[s][0], s == 1)};
			else
				expected_beats = {expected_beats, make_beat(st, s, 0, 0, 0, s == 1)};
	endtask

	// request beat taken at this rising edge
	always @(posedge clk) begin
		req_taken <= arst_n && req_valid && !req_stall;
	end

	// request driver: changes on the falling edge, the beat is taken at the rising edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_wait <= 0;
		end else if (req_taken) begin
			// beat taken at the last rising edge
			predict_book(order_req_t'({func, oid, side, price}));
			req_valid <= 1'b0;
			req_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
		end else if (!req_valid) begin
			if (req_wait > 0)
				req_wait <= req_wait - 1;
			else if (pending_reqs.size() > 0) begin
				order_req_t r;
				r = pending_reqs.pop_front();
				func <= r.func;
				oid <= r.oid;
				side <= r.side;
				price <= r.price;
				req_valid <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			book_beat_t got;
			book_beat_t exp;
			got = {status, side_res, valid_res, oid_res, price_res, last};
			if (expected_beats.size() == 0)
				report_mismatch($sformatf("unexpected beat %h", got));
			else begin
				exp = expected_beats.pop_front();
				if (got.status !== exp.status)
					report_mismatch($sformatf("status %0d want %0d", got.status, exp.status));
				if (got.side_res !== exp.side_res)
					report_mismatch($sformatf("side_res %0d want %0d",
						got.side_res, exp.side_res));
				if (got.valid_res !== exp.valid_res)
					report_mismatch($sformatf("valid_res %0d want %0d",
						got.valid_res, exp.valid_res));
				if (got.oid_res !== exp.oid_res)
					report_mismatch($sformatf("oid_res %0d want %0d",
						got.oid_res, exp.oid_res));
				if (got.price_res !== exp.price_res)
					report_mismatch($sformatf("price_res %0d want %0d",
						got.price_res, exp.price_res));
				if (got.last !== exp.last)
					report_mismatch($sformatf("last %0d want %0d", got.last, exp.last));
			end
		end
	end

	// consumer stall drawn per beat at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_wait <= 0;
		end else if (res_wait > 0) begin
			res_wait <= res_wait - 1;
			res_stall <= 1'b1;
		end else if (res_valid && !res_stall) begin
			int w;
			w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
			res_wait <= w;
			res_stall <= w > 0;
		end else
			res_stall <= 1'b0;
	end

	task automatic push_req(input func_t f, input int id, input int s, input int p);
		order_req_t r;
		r.func = f;
		r.oid = id[ORD_AW-1:0];
		r.side = s[0];
		r.price = p[PRICE_W-1:0];
		pending_reqs = {pending_reqs, r};
	endtask

	// wait until every request is sent and every beat has come back
	task automatic drain_book;
		while (pending_reqs.size() > 0 || req_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_depth(input int d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d[DEPTH_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		depth_reg = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random phase: mostly inserts and removes of random orders
	task automatic random_phase(input int n, input int lo, input int hi);
		int id;
		int s;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 45) begin
				id = $urandom_range(0, MAX_ORDERS - 1);
				push_req(FN_INSERT, id, $urandom_range(0, 1), $urandom_range(lo, hi));
			end else if (k < 80) begin
				// remove a random order id with a random side and price
				id = $urandom_range(0, MAX_ORDERS - 1);
				s = $urandom_range(0, 1);
				push_req(FN_REMOVE, id, s, $urandom_range(lo, hi));
			end else if (k < 90)
				push_req(FN_SNAPSHOT, $urandom, $urandom, $urandom);
			else if (k < 94)
				push_req(FN_SPARE, $urandom, $urandom, $urandom);
			else
				push_req(func_t'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
		end
	endtask

	// removes that match resting orders, drawn from the shadow book once idle
	task automatic clean_phase(input int n);
		int id;
		for (int i = 0; i < n; i++) begin
			id = $urandom_range(0, MAX_ORDERS - 1);
			for (int j = 0; j < MAX_ORDERS && !ord_used[id]; j++)
				id = (id + 1) % MAX_ORDERS;
			if (ord_used[id])
				push_req(FN_REMOVE, id, ord_side[id], ord_price[id]);
			drain_book();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		res_stall = 1'b0;
		func = '0;
		oid = '0;
		side = 1'b0;
		price = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		req_taken = 0;
		req_wait = 0;
		res_wait = 0;
		for (int i = 0; i < MAX_ORDERS; i++) begin
			ord_used[i] = 0;
			ord_prv[i] = NIL;
			ord_nxt[i] = NIL;
		end
		lvl_cnt[0] = 0;
		lvl_cnt[1] = 0;
		depth_reg = DEPTH_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty book, extremes, dup, unknown, mismatch, fifo order
		push_req(FN_SNAPSHOT, 0, 0, 0);
		push_req(FN_REMOVE, 5, 0, 100);
		push_req(FN_SPARE, 1023, 1, 65535);
		push_req(FN_INSERT, 0, 0, 0);
		push_req(FN_INSERT, 1023, 1, 65535);
		push_req(FN_INSERT, 1023, 0, 5);
		push_req(FN_INSERT, 10, 0, 100);
		push_req(FN_INSERT, 11, 0, 100);
		push_req(FN_INSERT, 12, 1, 200);
		push_req(FN_INSERT, 13, 1, 150);
		push_req(FN_INSERT, 14, 0, 120);
		push_req(FN_REMOVE, 10, 1, 100);
		push_req(FN_REMOVE, 10, 0, 101);
		push_req(FN_SNAPSHOT, 0, 0, 0);
		push_req(FN_REMOVE, 10, 0, 100);
		push_req(FN_REMOVE, 14, 0, 120);
		push_req(FN_REMOVE, 10, 0, 100);
		push_req(FN_SPARE, 0, 0, 0);
		push_req(FN_SNAPSHOT, 682, 1, 43690);
		push_req(FN_INSERT, 341, 1, 21845);
		drain_book();

		// fill one side to the level limit, then ask for one more
		write_depth(1);
		for (int i = 0; i < MAX_LEVELS; i++)
			push_req(FN_INSERT, 100 + i, 0, 1000 + 7 * i);
		push_req(FN_INSERT, 200, 0, 5);
		push_req(FN_INSERT, 201, 0, 1000);
		push_req(FN_SNAPSHOT, 0, 0, 0);
		drain_book();

		write_depth(0);
		random_phase(80, 0, 40);
		drain_book();
		clean_phase(20);
		write_depth(15);
		random_phase(80, 0, 65535);
		drain_book();
		write_depth(3);
		random_phase(90, 10, 30);
		drain_book();
		clean_phase(20);
		write_depth(8);
		random_phase(60, 0, 20);
		drain_book();

		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== price_time_order_book.f =====
+incdir+design
design/ptob_pkg.sv
design/ptob_ctrl.sv
design/ptob_dpath.sv
design/price_time_order_book.sv
test/tb.sv
